FILE: hdl/i2c_master_transaction_sequencer_assert.svh
// Assertion macros used by the I2C master transaction sequencer top level.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define I2CMTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define I2CMTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/i2cmts_pkg.sv
// Types and constants shared by the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cmts_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 40;

    // Command codes carried in tuser.
    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_START_WR = 3'd1,
        CMD_START_RD = 3'd2,
        CMD_BUS_EVT  = 3'd3,
        CMD_BUS_ERR  = 3'd4
    } cmd_t;

    // Transaction phases.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WR_ADDR = 3'd1,
        PH_WR_DATA = 3'd2,
        PH_RD_ADDR = 3'd3,
        PH_RD_DATA = 3'd4
    } phase_t;

    // One input transaction, unpacked.
    typedef struct packed {
        cmd_t       command;
        logic [6:0] slave_address;
        logic [7:0] length;
        logic [7:0] buf_index;
        logic [7:0] byte_value;
        logic       flag_start_sent;
        logic       flag_addr_acked;
        logic       flag_tx_empty;
        logic       flag_rx_full;
    } in_item_t;

    // One result transaction, unpacked.
    typedef struct packed {
        logic       accepted;
        logic       start_request;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       stop_request;
        logic       ack_enable;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_res;
        logic       failed;
        logic       busy_res;
    } result_t;

    // Write buffer access from the controller.
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } wbuf_req_t;

endpackage

FILE: hdl/i2cmts_wbuf.sv
// Write data buffer with one write port and one registered read port.
`timescale 1ns / 1ps

module i2cmts_wbuf #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  logic                  aclk,
    input  i2cmts_pkg::wbuf_req_t req,
    output logic [7:0]            rd_data
);
    import i2cmts_pkg::*;

    localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // Store a loaded byte.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    // Read the entry the controller will point at next; a same-cycle write is forwarded.
    always_ff @(posedge aclk) begin
        if (req.we && (req.waddr == req.raddr)) begin
            rd_data_reg <= req.wdata;
        end else begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/i2cmts_ctrl.sv
// Transaction state and the single-step logic that forms each result.
`timescale 1ns / 1ps

module i2cmts_ctrl #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  i2cmts_pkg::in_item_t  item,
    input  logic [7:0]            rd_data,
    output i2cmts_pkg::result_t   result,
    output i2cmts_pkg::wbuf_req_t wbuf_req
);
    import i2cmts_pkg::*;

    localparam logic [8:0] DEPTH_9 = 9'(BUF_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [6:0] tgt_reg, tgt_next;
    logic [7:0] wlen_reg, wlen_next;
    logic [7:0] wpos_reg, wpos_next;
    logic [7:0] rlen_reg, rlen_next;
    logic [7:0] rpos_reg, rpos_next;
    logic       ack_reg, ack_next;

    logic [7:0] rpos_inc;
    logic [7:0] wpos_inc;
    logic       wr_more;
    logic       wr_in_range;
    logic       load_in_range;
    logic       is_idle;

    assign rpos_inc      = rpos_reg + 8'd1;
    assign wpos_inc      = wpos_reg + 8'd1;
    assign wr_more       = wpos_reg < wlen_reg;
    assign wr_in_range   = {1'b0, wpos_reg} < DEPTH_9;
    assign load_in_range = {1'b0, item.buf_index} < DEPTH_9;
    assign is_idle       = (phase_reg == PH_IDLE);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (item.command)
            CMD_START_WR: begin
                if (is_idle) phase_next = PH_WR_ADDR;
            end
            CMD_START_RD: begin
                if (is_idle && (item.length != 8'd0)) phase_next = PH_RD_ADDR;
            end
            CMD_BUS_EVT: begin
                unique case (phase_reg)
                    PH_WR_ADDR: begin
                        if (item.flag_start_sent) phase_next = PH_WR_DATA;
                    end
                    PH_WR_DATA: begin
                        if (item.flag_addr_acked && (wlen_reg == 8'd0)) begin
                            phase_next = PH_IDLE;
                        end else if (item.flag_tx_empty && !wr_more) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RD_ADDR: begin
                        if (item.flag_start_sent) phase_next = PH_RD_DATA;
                    end
                    PH_RD_DATA: begin
                        if (item.flag_rx_full && (rpos_inc == rlen_reg)) phase_next = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_BUS_ERR: begin
                phase_next = PH_IDLE;
            end
            default: begin
            end
        endcase
    end

    // Datapath updates and result fields.
    always_comb begin
        tgt_next  = tgt_reg;
        wlen_next = wlen_reg;
        wpos_next = wpos_reg;
        rlen_next = rlen_reg;
        rpos_next = rpos_reg;
        ack_next  = ack_reg;
        result    = '0;
        unique case (item.command)
            CMD_START_WR: begin
                if (is_idle) begin
                    tgt_next             = item.slave_address;
                    wlen_next            = item.length;
                    wpos_next            = 8'd0;
                    rlen_next            = 8'd0;
                    result.start_request = 1'b1;
                    result.accepted      = 1'b1;
                end
            end
            CMD_START_RD: begin
                if (is_idle && (item.length != 8'd0)) begin
                    tgt_next             = item.slave_address;
                    wlen_next            = 8'd0;
                    rlen_next            = item.length;
                    rpos_next            = 8'd0;
                    ack_next             = 1'b1;
                    result.start_request = 1'b1;
                    result.accepted      = 1'b1;
                end
            end
            CMD_BUS_EVT: begin
                unique case (phase_reg)
                    PH_WR_ADDR: begin
                        if (item.flag_start_sent) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = {tgt_reg, 1'b0};
                        end
                    end
                    PH_WR_DATA: begin
                        if (item.flag_addr_acked && (wlen_reg == 8'd0)) begin
                            result.stop_request = 1'b1;
                            result.done_res     = 1'b1;
                        end else if (item.flag_tx_empty) begin
                            if (wr_more) begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = wr_in_range ? rd_data : 8'd0;
                                wpos_next       = wpos_inc;
                            end else begin
                                result.stop_request = 1'b1;
                                result.done_res     = 1'b1;
                            end
                        end
                    end
                    PH_RD_ADDR: begin
                        if (item.flag_start_sent) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = {tgt_reg, 1'b1};
                        end
                    end
                    PH_RD_DATA: begin
                        // NACK up front for a single-byte read.
                        if (item.flag_addr_acked) ack_next = (rlen_reg != 8'd1);
                        if (item.flag_rx_full) begin
                            result.rx_valid = 1'b1;
                            result.rx_byte  = item.byte_value;
                            result.rx_index = rpos_reg;
                            rpos_next       = rpos_inc;
                            // NACK the last byte, then re-enable once it has arrived.
                            if ((rlen_reg > 8'd1) &&
                                (({1'b0, rpos_reg} + 9'd2) == {1'b0, rlen_reg})) begin
                                ack_next = 1'b0;
                            end
                            if (rpos_inc == rlen_reg) begin
                                result.stop_request = 1'b1;
                                result.done_res     = 1'b1;
                                ack_next            = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_BUS_ERR: begin
                result.stop_request = 1'b1;
                result.done_res     = 1'b1;
                result.failed       = 1'b1;
            end
            default: begin
            end
        endcase
        result.ack_enable = ack_next;
        result.busy_res   = (phase_next != PH_IDLE);
    end

    // Buffer access: loads write, reads follow the position the next step will use.
    always_comb begin
        wbuf_req.we    = advance && (item.command == CMD_LOAD) && load_in_range;
        wbuf_req.waddr = item.buf_index;
        wbuf_req.wdata = item.byte_value;
        wbuf_req.raddr = advance ? wpos_next : wpos_reg;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tgt_reg   <= 7'd0;
            wlen_reg  <= 8'd0;
            wpos_reg  <= 8'd0;
            rlen_reg  <= 8'd0;
            rpos_reg  <= 8'd0;
            ack_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            tgt_reg   <= tgt_next;
            wlen_reg  <= wlen_next;
            wpos_reg  <= wpos_next;
            rlen_reg  <= rlen_next;
            rpos_reg  <= rpos_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

FILE: hdl/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
//
//  Channel  Direction  Contents
//  s_       in         tuser: command; tdata: address, length, index, byte, event flags
//  m_       out        tdata: one status and data transaction per input transaction
//
// Each input transaction passes an input register, one step of control logic and a
// result register, one transaction per cycle sustained while m_tready does not stall it.
// The write buffer is read ahead at the position the next step will use.
// Reset (aresetn low, synchronous) empties both registers and returns to idle.
// A stalled result holds its register; s_tready stays high while the result register
// is empty or being taken.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [6:0] slave_address, [14:7] length, [22:15] buf_index, [30:23] byte_value,
    // [31] flag_start_sent, [32] flag_addr_acked, [33] flag_tx_empty, [34] flag_rx_full
    input  logic [i2cmts_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [2:0] command
    input  logic [i2cmts_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] accepted, [1] start_request, [2] tx_valid, [10:3] tx_byte, [11] stop_request,
    // [12] ack_enable, [13] rx_valid, [21:14] rx_byte, [29:22] rx_index, [30] done_res,
    // [31] failed, [32] busy_res
    output logic [i2cmts_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import i2cmts_pkg::*;

`include "i2c_master_transaction_sequencer_assert.svh"

    in_item_t   in_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    logic       out_valid_reg;
    result_t    step_result;
    wbuf_req_t  wbuf_req;
    logic [7:0] rd_data;
    logic       advance;
    logic       s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.command         <= cmd_t'(s_tuser[2:0]);
            in_reg.slave_address   <= s_tdata[6:0];
            in_reg.length          <= s_tdata[14:7];
            in_reg.buf_index       <= s_tdata[22:15];
            in_reg.byte_value      <= s_tdata[30:23];
            in_reg.flag_start_sent <= s_tdata[31];
            in_reg.flag_addr_acked <= s_tdata[32];
            in_reg.flag_tx_empty   <= s_tdata[33];
            in_reg.flag_rx_full    <= s_tdata[34];
        end
    end

    i2cmts_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_reg),
        .rd_data  (rd_data),
        .result   (step_result),
        .wbuf_req (wbuf_req)
    );

    i2cmts_wbuf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_wbuf (
        .aclk    (aclk),
        .req     (wbuf_req),
        .rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.busy_res, out_reg.failed, out_reg.done_res,
                       out_reg.rx_index, out_reg.rx_byte, out_reg.rx_valid,
                       out_reg.ack_enable, out_reg.stop_request, out_reg.tx_byte,
                       out_reg.tx_valid, out_reg.start_request, out_reg.accepted};

    // Checks on the result register and the flow control.
    `I2CMTS_ASSERT(a_done_not_busy, out_valid_reg && out_reg.done_res |-> !out_reg.busy_res, "done result still reports busy")
    `I2CMTS_ASSERT(a_fail_done, out_valid_reg && out_reg.failed |-> out_reg.done_res, "failed without done")
    `I2CMTS_ASSERT(a_accept_start, out_valid_reg && out_reg.accepted |-> out_reg.start_request && out_reg.busy_res, "accepted start without start request")
    `I2CMTS_ASSERT(a_tx_rx_excl, out_valid_reg |-> !(out_reg.tx_valid && out_reg.rx_valid), "transmit and receive in one result")
    `I2CMTS_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> s_tready, "input stalled while result register empty")

endmodule
